// ===== hw/rtl/egt_pkg.sv =====
// Shared types, register codes and ROM generators for the exposure/gamma tone mapper.
`default_nettype none
package egt_pkg;

  typedef enum logic [0:0] {
    REG_EXPOSURE = 1'b0,
    REG_INV_GAMMA = 1'b1
  } reg_idx_t;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // restoring long division, only used while building the constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(65536 * 2^(-k/2^abits)), via a Q32 exp series
  function automatic logic [16:0] exp2_entry(input int unsigned k, input int unsigned abits);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    logic [127:0] prod;
    y = (64'(k) * LN2_Q32) >> abits;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int j = 1; j <= 20; j++) begin
      prod = 128'(term) * 128'(y);
      term = udiv64(64'(prod >> 32), 64'(j));
      sum = sum + term;
    end
    return 17'(udiv64((64'd1 << 48) + (sum >> 1), sum));
  endfunction

  // log2(1 + k/2^abits) in Q16 by repeated squaring
  function automatic logic [16:0] log2_entry(input int unsigned k, input int unsigned abits);
    logic [63:0] m;
    logic [31:0] r;
    if (k == (32'd1 << abits)) return ONE_Q16;
    m = (64'd1 << 30) + (64'(k) << (30 - abits));
    r = '0;
    for (int j = 0; j < 20; j++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r | 32'd1;
      end
    end
    return 17'((r + 32'd8) >> 4);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/egt_channel.sv =====
// One color channel of the tone map pipeline, eight register stages.
`default_nettype none
module egt_channel #(
  parameter int TABLE_ADDR_BITS = 8,
  parameter int INPUT_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [23:0] hdr,
  input  wire logic [15:0] exposure,
  input  wire logic [15:0] inv_gamma,
  output logic      [7:0]  ldr
);
  localparam int N = 1 << TABLE_ADDR_BITS;
  localparam int SS = 16 - TABLE_ADDR_BITS;
  localparam int TSH = INPUT_FRAC_BITS - 8;

  function automatic logic [N:0][16:0] exp2_table();
    logic [N:0][16:0] t;
    for (int k = 0; k <= N; k++) t[k] = egt_pkg::exp2_entry(k, TABLE_ADDR_BITS);
    return t;
  endfunction

  function automatic logic [N:0][16:0] log2_table();
    logic [N:0][16:0] t;
    for (int k = 0; k <= N; k++) t[k] = egt_pkg::log2_entry(k, TABLE_ADDR_BITS);
    return t;
  endfunction

  localparam logic [N:0][16:0] EXP2_ROM = exp2_table();
  localparam logic [N:0][16:0] LOG2_ROM = log2_table();

  function automatic logic [16:0] interp(input logic [16:0] a, input logic [16:0] b,
                                         input logic [SS-1:0] q);
    logic [SS+16:0] d;
    if (b >= a) begin
      d = 17'(b - a) * q;
      return a + 17'(d >> SS);
    end
    d = 17'(a - b) * q;
    return a - 17'(d >> SS);
  endfunction

  // stage 1: t = v * exposure
  logic [39:0] t_r;
  logic [15:0] g1_r;
  always_ff @(posedge clk) if (en) begin
    t_r <= 40'((64'(hdr) * 64'(exposure)) >> TSH);
    g1_r <= inv_gamma;
  end

  // stage 2: u = t * log2(e)
  logic [56:0] u_r;
  logic [15:0] g2_r;
  always_ff @(posedge clk) if (en) begin
    u_r <= 57'((64'(t_r) * 64'(egt_pkg::LOG2E_Q16)) >> 16);
    g2_r <= g1_r;
  end

  // stage 3: c = 1 - exp2(-u)
  logic [16:0] c_r;
  logic [15:0] g3_r;
  always_ff @(posedge clk) if (en) begin
    logic [16:0] e;
    logic [TABLE_ADDR_BITS-1:0] i;
    i = u_r[15:SS];
    e = interp(EXP2_ROM[{1'b0, i}], EXP2_ROM[{1'b0, i} + 1'b1], u_r[SS-1:0]);
    e = (u_r[56:16] >= 41'd32) ? 17'd0 : (e >> u_r[20:16]);
    c_r <= egt_pkg::ONE_Q16 - e;
    g3_r <= g2_r;
  end

  // stage 4: normalize c (leading one search over 17 bits)
  logic [4:0]  sh_r;
  logic [15:0] mf_r;
  logic        cz_r;
  logic [15:0] g4_r;
  always_ff @(posedge clk) if (en) begin
    logic [4:0] p;
    logic [32:0] m;
    p = '0;
    for (int b = 0; b <= 16; b++) if (c_r[b]) p = 5'(b);
    m = 33'(c_r) << (5'd16 - p);
    sh_r <= 5'd16 - p;
    mf_r <= m[15:0];
    cz_r <= c_r == '0;
    g4_r <= g3_r;
  end

  // stage 5: L = -log2(c)
  logic [20:0] l_r;
  logic        cz5_r;
  logic [15:0] g5_r;
  always_ff @(posedge clk) if (en) begin
    logic [TABLE_ADDR_BITS-1:0] i;
    logic [16:0] lg;
    i = mf_r[15:SS];
    lg = interp(LOG2_ROM[{1'b0, i}], LOG2_ROM[{1'b0, i} + 1'b1], mf_r[SS-1:0]);
    l_r <= 21'({sh_r, 16'd0}) - 21'(lg);
    cz5_r <= cz_r;
    g5_r <= g4_r;
  end

  // stage 6: w = L * inverse_gamma
  logic [22:0] w_r;
  logic        cz6_r;
  logic        gz6_r;
  always_ff @(posedge clk) if (en) begin
    w_r <= 23'((37'(l_r) * 37'(g5_r)) >> 14);
    cz6_r <= cz5_r;
    gz6_r <= g5_r == '0;
  end

  // stage 7: r = exp2(-w)
  logic [16:0] r_r;
  logic        cz7_r;
  logic        gz7_r;
  always_ff @(posedge clk) if (en) begin
    logic [TABLE_ADDR_BITS-1:0] i;
    logic [16:0] e;
    i = w_r[15:SS];
    e = interp(EXP2_ROM[{1'b0, i}], EXP2_ROM[{1'b0, i} + 1'b1], w_r[SS-1:0]);
    r_r <= (w_r[22:16] >= 7'd32) ? 17'd0 : (e >> w_r[20:16]);
    cz7_r <= cz6_r;
    gz7_r <= gz6_r;
  end

  // stage 8: scale to 8 bits
  always_ff @(posedge clk) if (en) begin
    logic [16:0] r;
    logic [24:0] s;
    r = (r_r > egt_pkg::ONE_Q16) ? egt_pkg::ONE_Q16 : r_r;
    s = 25'(r) * 25'd255;
    if (gz7_r) ldr <= 8'd255;
    else if (cz7_r) ldr <= 8'd0;
    else ldr <= s[23:16];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/exposure_gamma_tonemap.sv =====
// Top level of the exposure/gamma tone mapper: stream ports, config registers, pipeline.
// Usage:
//   in_tdata carries one HDR pixel per beat (red, green, blue, unsigned 24 bits
//   each, INPUT_FRAC_BITS fraction bits). out_tdata returns one 8-bit RGB pixel
//   per beat. Exposure (Q8.8) and inverse gamma (Q2.14) are written through the
//   cfg_ channel, index 0 and 1; other indexes are dropped. cfg_ready is always
//   high; write only while the pipeline is empty.
// Pipeline: each input beat passes the per-channel register stages (three multiplies,
//   three ROM interpolations, a normalize and a scale) before output valid.
// Throughput: one pixel per cycle while the output is not stalled; the three channels run in parallel lanes.
// Stall: when the output stage holds a beat and out_tready is low, the whole
//   pipeline holds and in_tready drops; otherwise it advances and bubbles move
//   on toward the output. No beat is lost or repeated.
// Reset: rst_n low clears all valid bits and restores exposure 1.0 and inverse
//   gamma 1/2.2.
`default_nettype none
module exposure_gamma_tonemap #(
  parameter int TABLE_ADDR_BITS = 8,
  parameter int INPUT_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // hdr_red, hdr_green, hdr_blue
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // ldr_red, ldr_green, ldr_blue
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int DEPTH = 8;

  logic [15:0] exposure_r;
  logic [15:0] inv_gamma_r;
  logic [DEPTH-1:0] vld_r;
  logic en;

  assign cfg_ready = 1'b1;
  // advance whenever the last stage is empty or being taken
  assign en = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r <= 16'd256;
      inv_gamma_r <= 16'd7447;
    end else if (cfg_valid) begin
      case (cfg_index)
        egt_pkg::REG_EXPOSURE:  exposure_r <= cfg_data;
        egt_pkg::REG_INV_GAMMA: inv_gamma_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    egt_channel #(
      .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
      .INPUT_FRAC_BITS(INPUT_FRAC_BITS)
    ) u_lane (
      .clk(clk),
      .en(en),
      .hdr(in_tdata[24*ch +: 24]),
      .exposure(exposure_r),
      .inv_gamma(inv_gamma_r),
      .ldr(out_tdata[8*ch +: 8])
    );
  end
endmodule
`default_nettype wire

// ===== test/exposure_gamma_tonemap_test.sv =====
// Self-checking testbench for the exposure/gamma tone mapper stream block.
module exposure_gamma_tonemap_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ABITS = 8;
  localparam int FRAC = 16;
  localparam int SEGS = 1 << ABITS;
  localparam int SSH = 16 - ABITS;
  localparam int RANDOM_PIXELS = 1900;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } ldr_pixel_t;

  // Tone curve model: builds its own copies of both tables and the registers.
  class tone_scoreboard;
    bit [31:0] exp2_tab[SEGS + 1];
    bit [31:0] log2_tab[SEGS + 1];
    bit [15:0] exposure;
    bit [15:0] inv_gamma;
    ldr_pixel_t pending[$];
    int errors;
    int checked;

    function new();
      bit [63:0] y, sum, term, m;
      bit [127:0] prod;
      bit [31:0] r;
      for (int k = 0; k <= SEGS; k++) begin
        y = (64'(k) * 64'd2977044472) >> ABITS;
        sum = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int j = 1; j <= 20; j++) begin
          prod = 128'(term) * 128'(y);
          term = 64'(prod >> 32) / 64'(j);
          sum += term;
        end
        exp2_tab[k] = 32'(((64'd1 << 48) + sum / 2) / sum);
        if (k == SEGS) log2_tab[k] = 65536;
        else begin
          m = (64'd1 << 30) + (64'(k) << (30 - ABITS));
          r = 0;
          for (int j = 0; j < 20; j++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd1 << 31)) begin
              m = m >> 1;
              r = r | 1;
            end
          end
          log2_tab[k] = (r + 8) >> 4;
        end
      end
      exposure = 256;
      inv_gamma = 7447;
    endfunction

    function bit [31:0] lerp(bit is_exp, bit [31:0] f);
      bit [31:0] i, a, b;
      bit [63:0] q;
      i = (f & 32'hFFFF) >> SSH;
      q = f & ((1 << SSH) - 1);
      a = is_exp ? exp2_tab[i] : log2_tab[i];
      b = is_exp ? exp2_tab[i + 1] : log2_tab[i + 1];
      if (b >= a) return a + 32'((64'(b - a) * q) >> SSH);
      return a - 32'((64'(a - b) * q) >> SSH);
    endfunction

    function bit [31:0] pow2_neg(bit [63:0] x);
      if ((x >> 16) >= 32) return 0;
      return lerp(1'b1, 32'(x & 64'hFFFF)) >> (x >> 16);
    endfunction

    function bit [7:0] map_lane(bit [23:0] v);
      bit [63:0] t, u, c, l, w, r;
      int p;
      t = (64'(v) * exposure) >> (FRAC - 8);
      u = (t * 64'd94548) >> 16;
      c = 64'd65536 - pow2_neg(u);
      if (inv_gamma == 0) return 8'd255;
      if (c == 0) return 8'd0;
      p = 16;
      while (p > 0 && (c >> p) == 0) p--;
      l = 64'(16 - p) * 65536 - lerp(1'b0, 32'((c << (16 - p)) - 65536));
      w = (l * inv_gamma) >> 14;
      r = pow2_neg(w);
      if (r > 65536) r = 65536;
      return 8'((r * 255) >> 16);
    endfunction

    function void write_reg(egt_pkg::reg_idx_t idx, bit [15:0] val);
      if (idx == egt_pkg::REG_EXPOSURE) exposure = val;
      else inv_gamma = val;
    endfunction

    function void note_pixel(bit [71:0] hdr);
      ldr_pixel_t e;
      e.red = map_lane(hdr[23:0]);
      e.green = map_lane(hdr[47:24]);
      e.blue = map_lane(hdr[71:48]);
      pending = {pending, e};
    endfunction

    function void check_pixel(ldr_pixel_t got);
      ldr_pixel_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected output beat %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.red !== e.red) begin
        $error("ldr_red expected %0d actual %0d", e.red, got.red);
        errors++;
      end
      if (got.green !== e.green) begin
        $error("ldr_green expected %0d actual %0d", e.green, got.green);
        errors++;
      end
      if (got.blue !== e.blue) begin
        $error("ldr_blue expected %0d actual %0d", e.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;   // hdr_red, hdr_green, hdr_blue
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;       // ldr_red, ldr_green, ldr_blue
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tone_scoreboard sb = new();
  bit hold_off = 1'b0;   // long receiver stall requested by the stimulus
  bit sink_busy = 1'b1;  // random back-pressure on/off

  always #5 clk = ~clk;

  exposure_gamma_tonemap dut (.*);

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata);
  end

  function automatic int pick_gap();
    // mostly none or short, now and then long
    int d = $urandom_range(0, 99);
    if (d < 55) return 0;
    if (d < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random tready; drop it for a long stretch when asked.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
        out_tready <= 1'b1;
      end else if (!sink_busy) out_tready <= 1'b1;
      else begin
        gap = pick_gap();
        if (gap == 0) out_tready <= 1'b1;
        else begin
          out_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send_pixel(input logic [71:0] px, input bit idle);
    int gap;
    gap = idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_cfg(input egt_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random radiance, biased toward the interesting small range.
  function automatic logic [23:0] rand_lane();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 255));
      2: return 24'($urandom_range(0, 65535));
      3: return 24'($urandom_range(0, 262143));
      4: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
      default: return 24'($urandom_range(0, 4095) << $urandom_range(0, 12));
    endcase
  endfunction

  initial begin
    logic [15:0] exp_set[6] = '{16'd256, 16'd0, 16'd1, 16'hFFFF, 16'd64, 16'd2048};
    logic [15:0] gam_set[6] = '{16'd7447, 16'd16384, 16'd1, 16'hFFFF, 16'd0, 16'd4096};
    logic [71:0] dir[$];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: corners of the radiance range with reset registers.
    dir = '{72'd0, {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, {24'd1, 24'd0, 24'h010000},
            {24'h008000, 24'h000100, 24'hAAAAAA}, {24'h555555, 24'h7FFFFF, 24'h800000},
            {24'h000001, 24'h000002, 24'h000004}, {24'h020000, 24'h100000, 24'h00FFFF}};
    foreach (dir[i]) send_pixel(dir[i], 1'b0);
    drain();
    // Zero exposure, zero inverse gamma, full-scale registers.
    write_cfg(egt_pkg::REG_EXPOSURE, 16'd0);
    send_pixel({24'hFFFFFF, 24'h010000, 24'd0}, 1'b0);
    drain();
    write_cfg(egt_pkg::REG_INV_GAMMA, 16'd0);
    send_pixel({24'hFFFFFF, 24'h010000, 24'd0}, 1'b0);
    drain();
    write_cfg(egt_pkg::REG_EXPOSURE, 16'hFFFF);
    write_cfg(egt_pkg::REG_INV_GAMMA, 16'hFFFF);
    foreach (dir[i]) send_pixel(dir[i], 1'b0);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(egt_pkg::REG_EXPOSURE, (ph < 5) ? exp_set[ph] : 16'($urandom));
      write_cfg(egt_pkg::REG_INV_GAMMA,
                (ph < 5) ? gam_set[ph] : 16'($urandom_range(1, 65535)));
      sink_busy = (ph != 2);
      for (int n = 0; n < RANDOM_PIXELS / 6; n++) begin
        if (ph == 1 && n == 20) hold_off = 1'b1;
        send_pixel({rand_lane(), rand_lane(), rand_lane()}, ph != 3);
      end
      drain();
    end

    $display("covered %0d output pixels over directed corners and six register phases",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("exposure_gamma_tonemap_test: clean");
    end else begin
      $display("exposure_gamma_tonemap_test: errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("exposure_gamma_tonemap_test: errors");
    $finish;
  end
endmodule
